// ----- hw/rtl/segment_free_list_allocator_macros.svh -----
// ----------------------------------------------------------------------------
// Segment free-list allocator assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_FREE_LIST_ALLOCATOR_MACROS_SVH
`define SEGMENT_FREE_LIST_ALLOCATOR_MACROS_SVH

// Same-cycle implication.
`define SFLA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define SFLA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/sfla_pkg.sv -----
// ----------------------------------------------------------------------------
// Segment free-list allocator package
// Request and response transaction types, codes and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package sfla_pkg;

  localparam int MAX_SEGMENTS_DEF = 32;
  localparam int OFFSET_BITS_DEF  = 32;
  localparam int FIELD_BITS       = 32;
  localparam logic [31:0] REGION_SIZE_RESET = 32'd65536;

  // Configuration register indexes.
  localparam logic REG_FIT_POLICY  = 1'b0;
  localparam logic REG_REGION_SIZE = 1'b1;

  // Free table ordering policies.
  localparam logic [1:0] POL_ASC_SIZE  = 2'd0;
  localparam logic [1:0] POL_DESC_SIZE = 2'd1;
  localparam logic [1:0] POL_ADDRESS   = 2'd2;

  typedef enum logic [1:0] {
    REQ_ALLOC  = 2'd0,
    REQ_FREE   = 2'd1,
    REQ_LOOKUP = 2'd2,
    REQ_MARK   = 2'd3
  } req_kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_FIT    = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_BAD_SIZE  = 3'd4
  } status_t;

  typedef struct packed {
    req_kind_t              req_type;
    logic [FIELD_BITS-1:0]  req_size;
    logic [FIELD_BITS-1:0]  address;
    logic                   strict_match;
    logic                   mark_value;
  } req_t;

  typedef struct packed {
    status_t                status;
    logic [FIELD_BITS-1:0]  seg_start;
    logic [FIELD_BITS-1:0]  seg_size;
    logic                   seg_marked;
  } rsp_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sfla_ram.sv -----
// ----------------------------------------------------------------------------
// Segment table RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sfla_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/segment_free_list_allocator.sv -----
// ----------------------------------------------------------------------------
// Segment free-list allocator
// Allocate, free, look up and mark segments of an offset region kept in a
// policy-ordered free table and a table of allocated segments.
// ----------------------------------------------------------------------------
// Usage: requests arrive on the req channel (valid/ready) and each one gives
// exactly one response transaction on the rsp channel (valid/ready). The
// block works on one request at a time; req_ready is high only while it is
// idle. A finished response sits in an output register, so a new request is
// taken while the receiver stalls on the previous response.
// The work is done in passes over the used-slot RAM and the free table RAM,
// which has one write and one read port and streams one entry per cycle: a
// pass over all MAX_SEGMENTS used slots (ending early when a slot hits), then
// for allocate a first-fit pass, a shift-down removal and, when a remainder
// is left, an insert position pass and a shift-up pass, and for free a full
// merge pass, up to two removals and the same two insert passes. Lookup and
// set mark finish after the used-slot pass. After reset or a region_size
// write the block writes the initial free segment, then becomes ready.
// Configuration writes take effect at once and must be made while idle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "segment_free_list_allocator_macros.svh"

module segment_free_list_allocator
  import sfla_pkg::*;
#(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
  parameter int OFFSET_BITS  = OFFSET_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_ready,
  input  wire req_t        req,
  output logic             rsp_valid,
  input  wire logic        rsp_ready,
  output rsp_t             rsp,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_addr,
  input  wire logic [31:0] cfg_wdata
);

  localparam int OW   = OFFSET_BITS;
  localparam int CW   = (OFFSET_BITS > FIELD_BITS) ? OFFSET_BITS : FIELD_BITS;
  localparam int IW   = $clog2(MAX_SEGMENTS);
  localparam int CNTW = $clog2(MAX_SEGMENTS + 1);
  localparam logic [CW-1:0]   OFS_MASK = CW'((65'd1 << OFFSET_BITS) - 65'd1);
  localparam logic [CNTW-1:0] MAX_CNT  = CNTW'(MAX_SEGMENTS);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_USCAN, S_FSCAN, S_MSCAN, S_RMV, S_IPOS, S_ISHF, S_IWR, S_DONE
  } state_t;

  state_t state;

  // Configuration.
  logic [1:0]    fit_policy;
  logic [OW-1:0] region_eff;

  // Free table count and allocated-slot flags.
  logic [CNTW-1:0]         cnt;
  logic [MAX_SEGMENTS-1:0] used_valid;
  logic [MAX_SEGMENTS-1:0] used_mark;

  // Scan pipeline: rd_idx is the next entry to read, tag_idx the entry whose
  // data sits on the RAM output this cycle.
  logic [CNTW-1:0] rd_idx;
  logic [IW-1:0]   tag_idx;
  logic            tag_vld;

  req_t            req_q;
  logic [IW-1:0]   slot;
  logic [OW-1:0]   seg_s;
  logic [OW-1:0]   seg_z;
  logic [OW-1:0]   acc_s;     // segment to insert into the free table
  logic [OW-1:0]   acc_z;
  logic            ins_en;
  logic            lf;
  logic            rf;
  logic [IW-1:0]   left_idx;
  logic [IW-1:0]   right_idx;
  logic [IW-1:0]   rm_idx;
  logic [IW-1:0]   rem2;
  logic            rem2_en;
  logic [CNTW-1:0] pos;

  status_t         res_st;
  logic [OW-1:0]   res_s;
  logic [OW-1:0]   res_z;
  logic            res_m;

  // RAM ports.
  logic            fram_we;
  logic [IW-1:0]   fram_waddr;
  logic [2*OW-1:0] fram_wdata;
  logic [IW-1:0]   fram_raddr;
  logic [2*OW-1:0] fram_rdata;
  logic            uram_we;
  logic [2*OW-1:0] uram_wdata;
  logic [2*OW-1:0] uram_rdata;

  logic [OW-1:0] f_start;
  logic [OW-1:0] f_size;
  logic [OW-1:0] u_start;
  logic [OW-1:0] u_size;

  logic [CNTW-1:0] scan_limit;
  logic            scan_more;
  logic            scan_end;
  logic            strict_eff;
  logic            u_hit;
  logic            fit_hit;
  logic            left_hit;
  logic            right_hit;
  logic            gb_hit;
  logic            goes_before;
  logic [CW-1:0]   cfg_eff;

  assign f_start = fram_rdata[2*OW-1:OW];
  assign f_size  = fram_rdata[OW-1:0];
  assign u_start = uram_rdata[2*OW-1:OW];
  assign u_size  = uram_rdata[OW-1:0];

  assign req_ready = (state == S_IDLE);

  // Region sizes beyond the offset range are clamped to its top.
  assign cfg_eff = (CW'(cfg_wdata) > OFS_MASK) ? OFS_MASK : CW'(cfg_wdata);

  always_comb begin
    scan_limit = (state == S_USCAN) ? MAX_CNT : cnt;
    scan_more  = (rd_idx < scan_limit);
    scan_end   = !tag_vld && !scan_more;
  end

  // Used-slot match: allocate wants the first free slot, the others the first
  // valid slot by exact start or, for a loose lookup, by containment.
  always_comb begin
    strict_eff = (req_q.req_type == REQ_LOOKUP) ? req_q.strict_match : 1'b1;
    if (req_q.req_type == REQ_ALLOC) begin
      u_hit = tag_vld && !used_valid[tag_idx];
    end else begin
      u_hit = tag_vld && used_valid[tag_idx] &&
              ((CW'(u_start) == CW'(req_q.address)) ||
               (!strict_eff && (CW'(u_start) < CW'(req_q.address)) &&
                ((CW+1)'(req_q.address) < (CW+1)'(u_start) + (CW+1)'(u_size))));
    end
  end

  always_comb begin
    fit_hit   = tag_vld && (CW'(f_size) >= CW'(req_q.req_size));
    left_hit  = tag_vld && ((OW+1)'(f_start) + (OW+1)'(f_size) == (OW+1)'(seg_s));
    right_hit = tag_vld && ((OW+1)'(f_start) == (OW+1)'(seg_s) + (OW+1)'(seg_z));
  end

  // Insert position: a new entry goes before the first entry it precedes.
  always_comb begin
    case (fit_policy)
      POL_ASC_SIZE:  goes_before = (acc_z < f_size);
      POL_DESC_SIZE: goes_before = (acc_z > f_size);
      POL_ADDRESS:   goes_before = (acc_s < f_start);
      default:       goes_before = 1'b0;
    endcase
    gb_hit = tag_vld && goes_before;
  end

  // Free table RAM port selection.
  always_comb begin
    fram_we    = 1'b0;
    fram_waddr = tag_idx;
    fram_wdata = fram_rdata;
    fram_raddr = rd_idx[IW-1:0];
    case (state)
      S_INIT: begin
        fram_we    = 1'b1;
        fram_waddr = '0;
        fram_wdata = {{OW{1'b0}}, region_eff};
      end
      S_RMV: begin
        fram_we    = tag_vld;
        fram_waddr = tag_idx - 1'b1;
      end
      S_ISHF: begin
        fram_we    = tag_vld;
        fram_waddr = tag_idx + 1'b1;
        fram_raddr = IW'(rd_idx - 1'b1);
      end
      S_IWR: begin
        fram_we    = 1'b1;
        fram_waddr = pos[IW-1:0];
        fram_wdata = {acc_s, acc_z};
      end
      default: begin
      end
    endcase
  end

  assign uram_we    = (state == S_FSCAN) && fit_hit;
  assign uram_wdata = {f_start, OW'(req_q.req_size)};

  sfla_ram #(
    .WIDTH (2 * OW),
    .DEPTH (MAX_SEGMENTS)
  ) u_free_ram (
    .clk   (clk),
    .we    (fram_we),
    .waddr (fram_waddr),
    .wdata (fram_wdata),
    .raddr (fram_raddr),
    .rdata (fram_rdata)
  );

  sfla_ram #(
    .WIDTH (2 * OW),
    .DEPTH (MAX_SEGMENTS)
  ) u_used_ram (
    .clk   (clk),
    .we    (uram_we),
    .waddr (slot),
    .wdata (uram_wdata),
    .raddr (rd_idx[IW-1:0]),
    .rdata (uram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      fit_policy <= POL_ASC_SIZE;
      region_eff <= OW'(((CW'(REGION_SIZE_RESET) > OFS_MASK) ? OFS_MASK
                                                             : CW'(REGION_SIZE_RESET)));
      used_valid <= '0;
      used_mark  <= '0;
      cnt        <= '0;
      tag_vld    <= 1'b0;
      rd_idx     <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end

      // Forward scan step shared by the scanning states. The shift-up pass
      // walks downward and steps its own pointer.
      if (state != S_ISHF) begin
        if (scan_more) begin
          rd_idx  <= rd_idx + 1'b1;
          tag_idx <= rd_idx[IW-1:0];
          tag_vld <= 1'b1;
        end else begin
          tag_vld <= 1'b0;
        end
      end

      case (state)
        S_INIT: begin
          cnt   <= (region_eff != '0) ? CNTW'(1) : '0;
          state <= S_IDLE;
        end

        S_IDLE: begin
          tag_vld <= 1'b0;
          rd_idx  <= '0;
          if (req_valid) begin
            req_q  <= req;
            res_s  <= '0;
            res_z  <= '0;
            res_m  <= 1'b0;
            if (req.req_type == REQ_ALLOC && req.req_size == '0) begin
              res_st <= ST_BAD_SIZE;
              state  <= S_DONE;
            end else begin
              state <= S_USCAN;
            end
          end
        end

        S_USCAN: begin
          if (u_hit) begin
            slot    <= tag_idx;
            seg_s   <= u_start;
            seg_z   <= u_size;
            acc_s   <= u_start;
            acc_z   <= u_size;
            lf      <= 1'b0;
            rf      <= 1'b0;
            rd_idx  <= '0;
            tag_vld <= 1'b0;
            case (req_q.req_type)
              REQ_ALLOC: state <= S_FSCAN;
              REQ_FREE:  state <= S_MSCAN;
              REQ_LOOKUP: begin
                res_st <= ST_OK;
                res_s  <= u_start;
                res_z  <= u_size;
                res_m  <= used_mark[tag_idx];
                state  <= S_DONE;
              end
              default: begin
                used_mark[tag_idx] <= req_q.mark_value;
                res_st <= ST_OK;
                res_s  <= u_start;
                res_z  <= u_size;
                res_m  <= req_q.mark_value;
                state  <= S_DONE;
              end
            endcase
          end else if (scan_end) begin
            res_st <= (req_q.req_type == REQ_ALLOC) ? ST_FULL : ST_NOT_FOUND;
            state  <= S_DONE;
          end
        end

        S_FSCAN: begin
          // First fit: the low part goes to the caller, the rest is reinserted.
          if (fit_hit) begin
            used_valid[slot] <= 1'b1;
            used_mark[slot]  <= 1'b0;
            res_st  <= ST_OK;
            res_s   <= f_start;
            res_z   <= OW'(req_q.req_size);
            ins_en  <= (CW'(f_size) > CW'(req_q.req_size));
            acc_s   <= OW'(CW'(f_start) + CW'(req_q.req_size));
            acc_z   <= f_size - OW'(req_q.req_size);
            rm_idx  <= tag_idx;
            rem2_en <= 1'b0;
            rd_idx  <= CNTW'(tag_idx) + 1'b1;
            tag_vld <= 1'b0;
            state   <= S_RMV;
          end else if (scan_end) begin
            res_st <= ST_NO_FIT;
            state  <= S_DONE;
          end
        end

        S_MSCAN: begin
          // Full pass: collect the free neighbors on both sides.
          if (left_hit) begin
            lf       <= 1'b1;
            left_idx <= tag_idx;
            acc_s    <= f_start;
            acc_z    <= acc_z + f_size;
          end else if (right_hit) begin
            rf        <= 1'b1;
            right_idx <= tag_idx;
            acc_z     <= acc_z + f_size;
          end
          if (scan_end) begin
            if (!lf && !rf && cnt >= MAX_CNT) begin
              res_st <= ST_FULL;
              state  <= S_DONE;
            end else begin
              used_valid[slot] <= 1'b0;
              used_mark[slot]  <= 1'b0;
              res_st  <= ST_OK;
              res_s   <= seg_s;
              res_z   <= seg_z;
              ins_en  <= 1'b1;
              rd_idx  <= '0;
              tag_vld <= 1'b0;
              rem2_en <= 1'b0;
              // Remove the higher index first so the lower one stays put.
              if (lf && rf) begin
                rm_idx  <= (left_idx > right_idx) ? left_idx : right_idx;
                rem2    <= (left_idx > right_idx) ? right_idx : left_idx;
                rem2_en <= 1'b1;
                rd_idx  <= CNTW'((left_idx > right_idx) ? left_idx : right_idx) + 1'b1;
                state   <= S_RMV;
              end else if (lf) begin
                rm_idx <= left_idx;
                rd_idx <= CNTW'(left_idx) + 1'b1;
                state  <= S_RMV;
              end else if (rf) begin
                rm_idx <= right_idx;
                rd_idx <= CNTW'(right_idx) + 1'b1;
                state  <= S_RMV;
              end else begin
                state <= S_IPOS;
              end
            end
          end
        end

        S_RMV: begin
          // Each entry above rm_idx moves down one place.
          if (scan_end) begin
            cnt     <= cnt - 1'b1;
            tag_vld <= 1'b0;
            if (rem2_en) begin
              rem2_en <= 1'b0;
              rm_idx  <= rem2;
              rd_idx  <= CNTW'(rem2) + 1'b1;
            end else if (ins_en) begin
              rd_idx <= '0;
              state  <= S_IPOS;
            end else begin
              state <= S_DONE;
            end
          end
        end

        S_IPOS: begin
          if (gb_hit || scan_end) begin
            pos     <= gb_hit ? CNTW'(tag_idx) : cnt;
            rd_idx  <= cnt;
            tag_vld <= 1'b0;
            state   <= S_ISHF;
          end
        end

        S_ISHF: begin
          // Walk down from the top, moving each entry up one place.
          if (rd_idx > pos) begin
            rd_idx  <= rd_idx - 1'b1;
            tag_idx <= IW'(rd_idx - 1'b1);
            tag_vld <= 1'b1;
          end else begin
            tag_vld <= 1'b0;
            if (!tag_vld) begin
              state <= S_IWR;
            end
          end
        end

        S_IWR: begin
          cnt   <= cnt + 1'b1;
          state <= S_DONE;
        end

        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp.status     <= res_st;
            rsp.seg_start  <= FIELD_BITS'(res_s);
            rsp.seg_size   <= FIELD_BITS'(res_z);
            rsp.seg_marked <= res_m;
            rsp_valid      <= 1'b1;
            state          <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase

      // Register writes; a new region empties both tables.
      if (cfg_wr_en) begin
        if (cfg_addr == REG_FIT_POLICY) begin
          fit_policy <= cfg_wdata[1:0];
        end else begin
          region_eff <= cfg_eff[OW-1:0];
          used_valid <= '0;
          used_mark  <= '0;
          state      <= S_INIT;
        end
      end
    end
  end

  `SFLA_ASSERT_NEXT(a_accept_leaves_idle, req_valid && req_ready, state != S_IDLE,
                    "accepted request did not start processing")
  `SFLA_ASSERT_NOW(a_insert_not_full, state == S_IPOS, cnt < MAX_CNT,
                   "insert pass started on a full free table")
  `SFLA_ASSERT_NEXT(a_insert_counts, state == S_IWR, cnt == CNTW'($past(cnt) + 1'b1),
                    "free count not advanced by insert")
  `SFLA_ASSERT_NEXT(a_done_delivers, state == S_DONE && (!rsp_valid || rsp_ready), rsp_valid,
                    "finished request did not load the response register")

endmodule

`default_nettype wire
